>>> sv/bitmap_slab_allocator_unit_macros.svh
`ifndef BITMAP_SLAB_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_SLAB_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT_NOW(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);
`define BSA_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSA_ASSERT_NOW(name, clk_sig, rst_sig, ante, cons, msg)
`define BSA_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

>>> sv/bsa_pkg.sv
package bsa_pkg;

    localparam int NUM_CHUNKS_DEF  = 16;
    localparam int NUM_CLASSES_DEF = 64;
    localparam int SLOTS_PER_CHUNK = 64;
    localparam int SLOT_BITS       = 6;

    localparam int CLASS_W  = 6;
    localparam int HANDLE_W = 10;
    localparam int OFFSET_W = 12;
    localparam int STATUS_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CLASS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic                command;
        logic [CLASS_W-1:0]  size_class;
        logic [HANDLE_W-1:0] handle;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] alloc_handle;
        logic [OFFSET_W-1:0] byte_offset;
        logic                chunk_opened;
        logic                chunk_closed;
    } result_t;

endpackage

>>> sv/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = bsa_pkg::SLOTS_PER_CHUNK,
    parameter int DEPTH = bsa_pkg::NUM_CHUNKS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bsa_find.sv
module bsa_find #(
    parameter int WIDTH = bsa_pkg::SLOTS_PER_CHUNK
) (
    input  logic [WIDTH-1:0]         bits,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] index
);

    localparam int IW = $clog2(WIDTH);

    // lowest clear bit
    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (!bits[i])
            begin
                found = 1'b1;
                index = IW'(i);
            end
        end
    end

endmodule

>>> sv/bitmap_slab_allocator_unit.sv
// Slab allocator over a pool of chunks with 64 slots each, one list per size class.
// Request channel: drive request and raise start; the request is taken at a clock
// edge where start is high and busy is low. Command alloc returns a handle and a
// byte offset from the head chunk of the class, opening a chunk when needed;
// command free clears the slot of the handle and returns an emptied chunk.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so the block never holds a result back.
// From accept to done: a bad class or bad chunk number is answered from idle; an
// alloc reads the class head, then opens a chunk in an empty class, or reads the
// head chunk record and fills a slot, or pushes a fresh chunk ahead of a full head
// chunk and then fixes the old head's back link. A free reads the chunk record; a
// free that empties the chunk also rewrites the class head or the record before it,
// then the record after it if any. An exhausted pool is reported at the head read in
// an empty class, at the record read behind a full head. A new request is taken in
// the cycle done rises. Reads are registered; each list neighbor is read-modify-written.
// Reset clears the sequencer, all chunk busy bits and all class head valid bits;
// every class starts with no chunk and every chunk is free.
`include "bitmap_slab_allocator_unit_macros.svh"

module bitmap_slab_allocator_unit #(
    parameter int NUM_CHUNKS  = bsa_pkg::NUM_CHUNKS_DEF,
    parameter int NUM_CLASSES = bsa_pkg::NUM_CLASSES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bsa_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output bsa_pkg::result_t   result
);

    localparam int CIW = $clog2(NUM_CHUNKS);
    localparam int CW  = $clog2(NUM_CHUNKS + 1);
    localparam int KW  = $clog2(NUM_CLASSES);
    localparam int SW  = bsa_pkg::SLOT_BITS;
    localparam int MW  = bsa_pkg::SLOTS_PER_CHUNK;
    localparam int HW  = bsa_pkg::HANDLE_W;
    localparam int OW  = bsa_pkg::OFFSET_W;
    localparam int HCW = HW - SW;

    localparam logic [CW-1:0] NO_CHUNK = CW'(NUM_CHUNKS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_HEAD    = 3'd1;
    localparam logic [2:0] S_AREAD   = 3'd2;
    localparam logic [2:0] S_FIXPREV = 3'd3;
    localparam logic [2:0] S_FREAD   = 3'd4;
    localparam logic [2:0] S_RDP     = 3'd5;
    localparam logic [2:0] S_RDN     = 3'd6;

    typedef struct packed {
        logic [bsa_pkg::CLASS_W-1:0] owner;
        logic [MW-1:0]               mask;
        logic [CW-1:0]               link_next;
        logic [CW-1:0]               link_prev;
    } rec_t;

    logic [2:0]               state_reg, state_next;
    bsa_pkg::request_t        req_reg, req_next;
    logic [CIW-1:0]           cur_reg, cur_next;
    logic [CIW-1:0]           new_reg, new_next;
    rec_t                     rec_reg, rec_next;
    logic [CW-1:0]            link_p_reg, link_p_next;
    logic [CW-1:0]            link_n_reg, link_n_next;
    logic [NUM_CHUNKS-1:0]    chunk_busy_reg, chunk_busy_next;
    logic [NUM_CLASSES-1:0]   head_vld_reg, head_vld_next;
    logic                     done_reg, done_next;
    bsa_pkg::result_t         result_reg, result_next;

    logic                     head_we, head_re;
    logic [KW-1:0]            head_waddr, head_raddr;
    logic [CW-1:0]            head_wdata, head_rdata;
    logic                     chunk_we, chunk_re;
    logic [CIW-1:0]           chunk_waddr, chunk_raddr;
    rec_t                     chunk_wdata, chunk_rdata;

    logic                     free_found;
    logic [CIW-1:0]           free_idx;
    logic                     slot_found;
    logic [SW-1:0]            slot_idx;

    logic                     in_cls_bad;
    logic [HCW-1:0]           in_chunk;
    logic                     in_chunk_ok;
    logic [KW-1:0]            cls_addr;
    logic [CW-1:0]            head_cur;
    logic [SW-1:0]            req_slot;
    logic [MW-1:0]            clr_mask;
    rec_t                     open_rec;

    bsa_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_CLASSES)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_en   (head_re),
        .rd_addr (head_raddr),
        .rd_data (head_rdata)
    );

    bsa_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (NUM_CHUNKS)
    ) u_chunk_ram (
        .clk     (clk),
        .wr_en   (chunk_we),
        .wr_addr (chunk_waddr),
        .wr_data (chunk_wdata),
        .rd_en   (chunk_re),
        .rd_addr (chunk_raddr),
        .rd_data (chunk_rdata)
    );

    bsa_find #(
        .WIDTH (NUM_CHUNKS)
    ) u_free_find (
        .bits  (chunk_busy_reg),
        .found (free_found),
        .index (free_idx)
    );

    bsa_find #(
        .WIDTH (MW)
    ) u_slot_find (
        .bits  (chunk_rdata.mask),
        .found (slot_found),
        .index (slot_idx)
    );

    assign in_cls_bad  = (request.size_class == '0) ||
                         (32'(request.size_class) >= NUM_CLASSES);
    assign in_chunk    = request.handle[HW-1:SW];
    assign in_chunk_ok = (32'(in_chunk) < NUM_CHUNKS) && chunk_busy_reg[CIW'(in_chunk)];
    assign cls_addr    = KW'(req_reg.size_class);
    assign head_cur    = head_vld_reg[cls_addr] ? head_rdata : NO_CHUNK;
    assign req_slot    = req_reg.handle[SW-1:0];
    assign clr_mask    = chunk_rdata.mask & ~(MW'(1) << req_slot);

    always_comb
    begin
        open_rec.owner     = req_reg.size_class;
        open_rec.mask      = MW'(1);
        open_rec.link_next = NO_CHUNK;
        open_rec.link_prev = NO_CHUNK;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        cur_next        = cur_reg;
        new_next        = new_reg;
        rec_next        = rec_reg;
        link_p_next     = link_p_reg;
        link_n_next     = link_n_reg;
        chunk_busy_next = chunk_busy_reg;
        head_vld_next   = head_vld_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        head_re     = 1'b0;
        head_raddr  = KW'(request.size_class);
        head_we     = 1'b0;
        head_waddr  = cls_addr;
        head_wdata  = CW'(free_idx);
        chunk_re    = 1'b0;
        chunk_raddr = CIW'(in_chunk);
        chunk_we    = 1'b0;
        chunk_waddr = free_idx;
        chunk_wdata = open_rec;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    if (in_cls_bad)
                    begin
                        result_next        = '0;
                        result_next.status = bsa_pkg::ST_BAD_CLASS;
                        done_next          = 1'b1;
                    end
                    else if (request.command == bsa_pkg::CMD_ALLOC)
                    begin
                        head_re    = 1'b1;
                        state_next = S_HEAD;
                    end
                    else if (!in_chunk_ok)
                    begin
                        result_next        = '0;
                        result_next.status = bsa_pkg::ST_BAD_FREE;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        chunk_re   = 1'b1;
                        cur_next   = CIW'(in_chunk);
                        state_next = S_FREAD;
                    end
                end
            end

            S_HEAD:
            begin
                if (head_cur != NO_CHUNK)
                begin
                    chunk_re    = 1'b1;
                    chunk_raddr = CIW'(head_cur);
                    cur_next    = CIW'(head_cur);
                    state_next  = S_AREAD;
                end
                else if (!free_found)
                begin
                    result_next        = '0;
                    result_next.status = bsa_pkg::ST_EXHAUSTED;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    // open a chunk in an empty class
                    chunk_we                  = 1'b1;
                    head_we                   = 1'b1;
                    head_vld_next[cls_addr]   = 1'b1;
                    chunk_busy_next[free_idx] = 1'b1;
                    result_next               = '0;
                    result_next.status        = bsa_pkg::ST_OK;
                    result_next.alloc_handle  = HW'({free_idx, {SW{1'b0}}});
                    result_next.chunk_opened  = 1'b1;
                    done_next                 = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            S_AREAD:
            begin
                if (slot_found)
                begin
                    chunk_we                 = 1'b1;
                    chunk_waddr              = cur_reg;
                    chunk_wdata              = chunk_rdata;
                    chunk_wdata.mask         = chunk_rdata.mask | (MW'(1) << slot_idx);
                    result_next              = '0;
                    result_next.status       = bsa_pkg::ST_OK;
                    result_next.alloc_handle = HW'({cur_reg, slot_idx});
                    result_next.byte_offset  = OW'(slot_idx) * OW'(req_reg.size_class);
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else if (!free_found)
                begin
                    result_next        = '0;
                    result_next.status = bsa_pkg::ST_EXHAUSTED;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    // push a fresh chunk ahead of the full head
                    chunk_we                  = 1'b1;
                    chunk_wdata.link_next     = CW'(cur_reg);
                    head_we                   = 1'b1;
                    head_vld_next[cls_addr]   = 1'b1;
                    chunk_busy_next[free_idx] = 1'b1;
                    new_next                  = free_idx;
                    rec_next                  = chunk_rdata;
                    result_next               = '0;
                    result_next.status        = bsa_pkg::ST_OK;
                    result_next.alloc_handle  = HW'({free_idx, {SW{1'b0}}});
                    result_next.chunk_opened  = 1'b1;
                    state_next                = S_FIXPREV;
                end
            end

            S_FIXPREV:
            begin
                chunk_we              = 1'b1;
                chunk_waddr           = cur_reg;
                chunk_wdata           = rec_reg;
                chunk_wdata.link_prev = CW'(new_reg);
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            S_FREAD:
            begin
                if (chunk_rdata.owner != req_reg.size_class)
                begin
                    result_next        = '0;
                    result_next.status = bsa_pkg::ST_BAD_FREE;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (clr_mask != '0)
                begin
                    chunk_we           = 1'b1;
                    chunk_waddr        = cur_reg;
                    chunk_wdata        = chunk_rdata;
                    chunk_wdata.mask   = clr_mask;
                    result_next        = '0;
                    result_next.status = bsa_pkg::ST_OK;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    // unlink the emptied chunk
                    chunk_busy_next[cur_reg] = 1'b0;
                    link_p_next              = chunk_rdata.link_prev;
                    link_n_next              = chunk_rdata.link_next;
                    result_next              = '0;
                    result_next.status       = bsa_pkg::ST_OK;
                    result_next.chunk_closed = 1'b1;
                    if (chunk_rdata.link_prev != NO_CHUNK)
                    begin
                        chunk_re    = 1'b1;
                        chunk_raddr = CIW'(chunk_rdata.link_prev);
                        state_next  = S_RDP;
                    end
                    else
                    begin
                        head_we                 = 1'b1;
                        head_wdata              = chunk_rdata.link_next;
                        head_vld_next[cls_addr] = 1'b1;
                        if (chunk_rdata.link_next != NO_CHUNK)
                        begin
                            chunk_re    = 1'b1;
                            chunk_raddr = CIW'(chunk_rdata.link_next);
                            state_next  = S_RDN;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_RDP:
            begin
                chunk_we              = 1'b1;
                chunk_waddr           = CIW'(link_p_reg);
                chunk_wdata           = chunk_rdata;
                chunk_wdata.link_next = link_n_reg;
                if (link_n_reg != NO_CHUNK)
                begin
                    chunk_re    = 1'b1;
                    chunk_raddr = CIW'(link_n_reg);
                    state_next  = S_RDN;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RDN:
            begin
                chunk_we              = 1'b1;
                chunk_waddr           = CIW'(link_n_reg);
                chunk_wdata           = chunk_rdata;
                chunk_wdata.link_prev = link_p_reg;
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chunk_busy_reg <= '0;
            head_vld_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chunk_busy_reg <= chunk_busy_next;
            head_vld_reg   <= head_vld_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        cur_reg    <= cur_next;
        new_reg    <= new_next;
        rec_reg    <= rec_next;
        link_p_reg <= link_p_next;
        link_n_reg <= link_n_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `BSA_ASSERT_NEXT(a_bad_class, clk, rst_n, start && !busy && in_cls_bad, done && result.status == bsa_pkg::ST_BAD_CLASS, "bad class not flagged at once")
    `BSA_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done, "accepted request neither running nor done")
    `BSA_ASSERT_NOW(a_err_clean, clk, rst_n, done && result.status != bsa_pkg::ST_OK, result.alloc_handle == '0 && result.byte_offset == '0 && !result.chunk_opened && !result.chunk_closed, "error result carries payload")
    `BSA_ASSERT_NOW(a_link_busy, clk, rst_n, chunk_we && (state_reg == S_RDP || state_reg == S_RDN), chunk_busy_reg[chunk_waddr], "link update on a free chunk")

endmodule
